// ----- rtl/lks_pkg.sv -----
// Shared types, constants and rotate helper for the LEA-192 key schedule.
`default_nettype none
package lks_pkg;

    // Number of round keys produced for one key
    localparam int ROUND_COUNT = 28;
    localparam int KEY_WORDS   = 6;
    localparam int WORD_W      = 32;
    localparam int ROUND_NUM_W = 5;

    // Round counter wide enough for the round count and the 5-bit round index
    localparam int CNT_W = ($clog2(ROUND_COUNT) > ROUND_NUM_W) ?
                           $clog2(ROUND_COUNT) : ROUND_NUM_W;
    localparam int SEL_W = $clog2(KEY_WORDS);

    typedef logic [WORD_W-1:0]          t_word;
    typedef t_word [KEY_WORDS-1:0]      t_words;
    typedef logic [ROUND_NUM_W-1:0]     t_rot;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [SEL_W-1:0]           t_sel;

    // Round constants, picked by round index modulo six
    localparam t_word DELTA [KEY_WORDS] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a,
        32'h78df30ec, 32'h715ea49e, 32'hc785da0a
    };

    // Final fixed rotation of each working word
    localparam t_rot WORD_ROT [KEY_WORDS] = '{
        5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17
    };

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Control handed from the sequencer to the round datapath
    typedef struct packed {
        t_word delta;
        t_rot  rot_base;
    } t_round_ctl;

    // Rotate left by 0..31; a zero amount leaves the word unchanged
    function automatic t_word rotl32(input t_word x, input t_rot n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lks_key_if.sv -----
// Input channel: one 192-bit key as six words with valid/ready.
`default_nettype none
interface lks_key_if;
    logic              valid;
    logic              ready;
    lks_pkg::t_word    key_word_0;
    lks_pkg::t_word    key_word_1;
    lks_pkg::t_word    key_word_2;
    lks_pkg::t_word    key_word_3;
    lks_pkg::t_word    key_word_4;
    lks_pkg::t_word    key_word_5;

    modport source (output valid, key_word_0, key_word_1, key_word_2,
                    key_word_3, key_word_4, key_word_5, input ready);
    modport sink   (input valid, key_word_0, key_word_1, key_word_2,
                    key_word_3, key_word_4, key_word_5, output ready);
endinterface
`default_nettype wire

// ----- rtl/lks_rk_if.sv -----
// Output channel: one round key with round index and last flag.
`default_nettype none
interface lks_rk_if;
    logic                                  valid;
    logic                                  ready;
    logic [lks_pkg::ROUND_NUM_W-1:0]       round_number;
    lks_pkg::t_word                        round_key_0;
    lks_pkg::t_word                        round_key_1;
    lks_pkg::t_word                        round_key_2;
    lks_pkg::t_word                        round_key_3;
    lks_pkg::t_word                        round_key_4;
    lks_pkg::t_word                        round_key_5;
    logic                                  last_round;

    modport source (output valid, round_number, round_key_0, round_key_1,
                    round_key_2, round_key_3, round_key_4, round_key_5,
                    last_round, input ready);
    modport sink   (input valid, round_number, round_key_0, round_key_1,
                    round_key_2, round_key_3, round_key_4, round_key_5,
                    last_round, output ready);
endinterface
`default_nettype wire

// ----- rtl/lks_round.sv -----
// Shared round datapath: six lanes of add rotated constant, then fixed rotate.
`default_nettype none
module lks_round (
    input  wire lks_pkg::t_words    i_words,
    input  wire lks_pkg::t_round_ctl i_ctl,
    output lks_pkg::t_words         o_words
);

    // Update each working word in its own lane
    always_comb begin
        for (int j = 0; j < lks_pkg::KEY_WORDS; j++) begin
            o_words[j] = lks_pkg::rotl32(
                i_words[j] + lks_pkg::rotl32(i_ctl.delta,
                                             i_ctl.rot_base + lks_pkg::t_rot'(j)),
                lks_pkg::WORD_ROT[j]);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lea192_key_schedule.sv -----
// LEA-192 key schedule: one key in, ROUND_COUNT round keys out.
// The first round key is registered on the first round step after the key is taken.
// Throughput: one round key per cycle from the shared round datapath while
//   the output side keeps up; the key is taken in the idle state, then
//   each step computes one round.
// A new key is taken once the last round key has been computed.
// Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending round key.
`default_nettype none
module lea192_key_schedule (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lks_key_if.sink   i_key,
    lks_rk_if.source  o_rk
);

    lks_pkg::t_state     r_state, n_state;
    lks_pkg::t_words     r_words;
    lks_pkg::t_words     w_next_words;
    lks_pkg::t_cnt       r_round;
    lks_pkg::t_sel       r_dsel;
    lks_pkg::t_round_ctl w_ctl;
    logic                r_out_valid;
    logic                w_key_acc;
    logic                w_step;
    logic                w_last;

    // Handshake and step conditions
    assign i_key.ready = (r_state == lks_pkg::ST_IDLE);
    assign w_key_acc   = i_key.valid && i_key.ready;
    assign w_step      = (r_state == lks_pkg::ST_RUN) && (!r_out_valid || o_rk.ready);
    assign w_last      = (r_round == lks_pkg::t_cnt'(lks_pkg::ROUND_COUNT - 1));

    // Build round control for the datapath
    assign w_ctl.delta    = lks_pkg::DELTA[r_dsel];
    assign w_ctl.rot_base = r_round[lks_pkg::ROUND_NUM_W-1:0];

    lks_round u_round (
        .i_words (r_words),
        .i_ctl   (w_ctl),
        .o_words (w_next_words)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lks_pkg::ST_IDLE: begin
                if (w_key_acc) n_state = lks_pkg::ST_RUN;
            end
            lks_pkg::ST_RUN: begin
                if (w_step && w_last) n_state = lks_pkg::ST_IDLE;
            end
            default: n_state = lks_pkg::ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lks_pkg::ST_IDLE;
            r_round     <= '0;
            r_dsel      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_key_acc) begin
                r_round <= '0;
                r_dsel  <= '0;
            end else if (w_step) begin
                r_round <= r_round + lks_pkg::t_cnt'(1);
                r_dsel  <= (r_dsel == lks_pkg::t_sel'(lks_pkg::KEY_WORDS - 1)) ?
                           '0 : r_dsel + lks_pkg::t_sel'(1);
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_rk.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load key words, then advance them one round per step
    always_ff @(posedge i_clk) begin
        if (w_key_acc) begin
            r_words[0] <= i_key.key_word_0;
            r_words[1] <= i_key.key_word_1;
            r_words[2] <= i_key.key_word_2;
            r_words[3] <= i_key.key_word_3;
            r_words[4] <= i_key.key_word_4;
            r_words[5] <= i_key.key_word_5;
        end else if (w_step) begin
            r_words <= w_next_words;
        end
    end

    // Register the round key in reversed word order
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            o_rk.round_number <= r_round[lks_pkg::ROUND_NUM_W-1:0];
            o_rk.round_key_0  <= w_next_words[5];
            o_rk.round_key_1  <= w_next_words[4];
            o_rk.round_key_2  <= w_next_words[3];
            o_rk.round_key_3  <= w_next_words[2];
            o_rk.round_key_4  <= w_next_words[1];
            o_rk.round_key_5  <= w_next_words[0];
            o_rk.last_round   <= w_last;
        end
    end

    assign o_rk.valid = r_out_valid;

`ifndef ASSERT_OFF
    // A taken key restarts the round count
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_acc |=> (r_state == lks_pkg::ST_RUN) && (r_round == '0) && (r_dsel == '0))
        else $error("key schedule did not restart at round zero");

    // Last flag only on the final round index
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rk.valid && o_rk.last_round) |->
        (o_rk.round_number ==
         lks_pkg::ROUND_NUM_W'(lks_pkg::ROUND_COUNT - 1)))
        else $error("last flag on wrong round");

    // Constant selector stays within the table
    a_dsel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dsel <= lks_pkg::t_sel'(lks_pkg::KEY_WORDS - 1))
        else $error("round constant selector out of range");

    // A non-final step advances the round by one
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_last) |=> (r_round == $past(r_round) + lks_pkg::t_cnt'(1)))
        else $error("round counter skipped");
`endif

endmodule
`default_nettype wire
